### design/bda_pkg.sv
// bda_pkg: shared types, constants and the double dabble step for the
// binary to decimal ascii converter. No dependencies.
package bda_pkg;

    // input value width and the part of it that is converted
    localparam int VALUE_W    = 30;
    localparam int BIN_BITS   = 30;
    localparam int DEC_DIGITS = 10;

    // conversion steps: STEP_BITS input bits are consumed per clock, except while the final step waits for queue room
    localparam int STEP_BITS = 3;
    localparam int STEPS     = (BIN_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_W     = STEPS * STEP_BITS;
    localparam int CNT_W     = $clog2(STEPS);

    // bcd word and digit index
    localparam int BCD_W     = 4 * DEC_DIGITS;
    localparam int DIG_IDX_W = $clog2(DEC_DIGITS);

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // ascii code of '0'; digits are or-ed into the low nibble
    localparam logic [5:0] ASCII_ZERO = 6'h30;
    localparam logic [3:0] ADD3_LIMIT = 4'h4;
    localparam logic [3:0] ADD3_VALUE = 4'h3;

    typedef logic [BCD_W-1:0]     bcd_t;
    typedef logic [DIG_IDX_W-1:0] dig_idx_t;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // one shift-and-add-3 step over all digits
    function automatic bcd_t dabble_step(input bcd_t bcd_in, input logic bin_bit);
        bcd_t       acc;
        logic [3:0] nib;
        acc = bcd_in;
        for (int d = 0; d < DEC_DIGITS; d++)
        begin
            nib = acc[4*d +: 4];
            if (nib > ADD3_LIMIT)
            begin
                acc[4*d +: 4] = nib + ADD3_VALUE;
            end
        end
        return {acc[BCD_W-2:0], bin_bit};
    endfunction

    // index of the most significant nonzero digit, zero if all digits are zero
    function automatic dig_idx_t top_digit(input bcd_t bcd_in);
        dig_idx_t top;
        top = '0;
        for (int d = 0; d < DEC_DIGITS; d++)
        begin
            if (bcd_in[4*d +: 4] != 4'h0)
            begin
                top = DIG_IDX_W'(d);
            end
        end
        return top;
    endfunction

endpackage

### design/bda_front.sv
// bda_front: accepts a binary value and converts it to bcd by double dabble,
// STEP_BITS bits per clock (the final step waits for room in the queue), then pushes the bcd word into the queue.
// Depends on bda_pkg.
module bda_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [bda_pkg::VALUE_W-1:0] value,
    output logic                        busy,
    input  bda_pkg::q_status_t          q_status,
    output logic                        push,
    output bda_pkg::bcd_t               push_data
);

    logic                            act_reg, act_next;
    logic [bda_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic [bda_pkg::PAD_W-1:0]       sh_reg, sh_next;
    bda_pkg::bcd_t                   bcd_reg, bcd_next;
    bda_pkg::bcd_t                   bcd_step;
    logic [bda_pkg::PAD_W-1:0]       sh_step;
    logic                            last_step;
    logic                            accept;
    logic                            advance;

    // three dependent dabble steps per clock, msb first
    always_comb
    begin
        bcd_step = bcd_reg;
        sh_step  = sh_reg;
        for (int i = 0; i < bda_pkg::STEP_BITS; i++)
        begin
            bcd_step = bda_pkg::dabble_step(bcd_step, sh_step[bda_pkg::PAD_W-1]);
            sh_step  = {sh_step[bda_pkg::PAD_W-2:0], 1'b0};
        end
    end

    // handshake: the final step completes only when the queue has room
    assign last_step = (cnt_reg == bda_pkg::CNT_W'(bda_pkg::STEPS - 1));
    assign push      = act_reg && last_step && !q_status.full;
    assign advance   = act_reg && !(last_step && q_status.full);
    assign busy      = act_reg && !push;
    assign accept    = start && !busy;
    assign push_data = bcd_step;

    // next state of the converter
    always_comb
    begin
        act_next = act_reg;
        cnt_next = cnt_reg;
        sh_next  = sh_reg;
        bcd_next = bcd_reg;
        if (accept)
        begin
            act_next = 1'b1;
            cnt_next = '0;
            sh_next  = bda_pkg::PAD_W'(value[bda_pkg::BIN_BITS-1:0]);
            bcd_next = '0;
        end
        else if (push)
        begin
            act_next = 1'b0;
        end
        else if (advance)
        begin
            cnt_next = cnt_reg + 1'b1;
            sh_next  = sh_step;
            bcd_next = bcd_step;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            act_reg <= act_next;
            cnt_reg <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        bcd_reg <= bcd_next;
    end

endmodule

### design/bda_fifo.sv
// bda_fifo: short flop queue of bcd words between the converter front and
// the character emitter. Depends on bda_pkg.
module bda_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  bda_pkg::bcd_t      wr_data,
    input  logic               rd_en,
    output bda_pkg::bcd_t      rd_data,
    output bda_pkg::q_status_t status
);

    bda_pkg::bcd_t                mem_reg [bda_pkg::QUEUE_DEPTH];
    logic [bda_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [bda_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [bda_pkg::QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                         do_wr, do_rd;

    assign status.full  = (cnt_reg == bda_pkg::QCNT_W'(bda_pkg::QUEUE_DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign do_wr        = wr_en && !status.full;
    assign do_rd        = rd_en && !status.empty;
    assign rd_data      = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == bda_pkg::QPTR_W'(bda_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == bda_pkg::QPTR_W'(bda_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### design/bda_emit.sv
// bda_emit: pops bcd words from the queue, skips leading zeros and sends one
// ascii digit per clock, most significant first. Depends on bda_pkg.
module bda_emit (
    input  logic               clk,
    input  logic               rst_n,
    input  bda_pkg::q_status_t q_status,
    input  bda_pkg::bcd_t      head,
    output logic               pop,
    output logic               valid,
    output logic [5:0]         ascii_char,
    output logic               last
);

    logic              act_reg, act_next;
    bda_pkg::dig_idx_t idx_reg, idx_next;
    bda_pkg::bcd_t     cur_reg, cur_next;
    logic              valid_reg;
    logic [5:0]        ascii_reg;
    logic              last_reg;
    logic [3:0]        nib;
    logic              final_digit;

    // current digit of the word in flight
    assign nib         = cur_reg[4*idx_reg +: 4];
    assign final_digit = (idx_reg == '0);

    // pop the next word as the last digit of the current one leaves, or while idle
    assign pop = (!act_reg || final_digit) && !q_status.empty;

    always_comb
    begin
        act_next = act_reg;
        idx_next = idx_reg;
        cur_next = cur_reg;
        if (act_reg && !final_digit)
        begin
            idx_next = idx_reg - 1'b1;
        end
        else if (pop)
        begin
            act_next = 1'b1;
            cur_next = head;
            idx_next = bda_pkg::top_digit(head);
        end
        else
        begin
            act_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg   <= 1'b0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            act_reg   <= act_next;
            idx_reg   <= idx_next;
            valid_reg <= act_reg;
        end
    end

    // character output register and word in flight
    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        ascii_reg <= bda_pkg::ASCII_ZERO | {2'b00, nib};
        last_reg  <= final_digit;
    end

    assign valid      = valid_reg;
    assign ascii_char = ascii_reg;
    assign last       = last_reg;

endmodule

### design/binary_to_decimal_ascii_top.sv
// binary_to_decimal_ascii_top: a value is taken when start is high and busy low;
// the front converts it 3 bits per cycle, holding the final step while the queue
// is full, then it queues. Characters then leave one per cycle, most significant first.
// A new value can be taken while the one before it is pushed; a full queue holds the front back.
// Reset clears all control state; results cannot be stalled by the receiver.
// Depends on bda_pkg, bda_front, bda_fifo and bda_emit.
module binary_to_decimal_ascii_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [bda_pkg::VALUE_W-1:0] value,
    output logic                        busy,
    output logic                        valid,
    output logic [5:0]                  ascii_char,
    output logic                        last
);

    bda_pkg::q_status_t q_status;
    logic               push;
    bda_pkg::bcd_t      push_data;
    logic               pop;
    bda_pkg::bcd_t      head;

    // converter front
    bda_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .value     (value),
        .busy      (busy),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    // queue between front and back
    bda_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (push_data),
        .rd_en   (pop),
        .rd_data (head),
        .status  (q_status)
    );

    // character emitter
    bda_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .head       (head),
        .pop        (pop),
        .valid      (valid),
        .ascii_char (ascii_char),
        .last       (last)
    );

endmodule
